// ----- src/tsms_pkg.sv -----
// Shared types, constants and arithmetic helpers for the max-plus surprise memory scan.
// Imported by every module of the block; depends on nothing.
package tsms_pkg;

    // Signed Q8.8 word
    typedef logic signed [15:0] t_q88;

    // Per-step control carried from the front end to the back end
    typedef struct packed {
        logic clear;
        t_q88 gain;
    } t_step_ctl;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PRED,
        BK_UPD,
        BK_READ,
        BK_EMIT
    } t_back_state;

    // Clamp a wide signed value to the Q8.8 range
    function automatic t_q88 sat16(input logic signed [63:0] x);
        t_q88 r;
        if (x > 64'sd32767) begin
            r = 16'sh7fff;
        end else if (x < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = 16'(x);
        end
        return r;
    endfunction

    // round(65536 / sqrt(dim)) as unsigned Q1.16, evaluated at elaboration
    function automatic logic [16:0] inv_root(input int unsigned dim);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned t;
        lo = 0;
        hi = 65536;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            t   = 2 * mid + 1;
            if (t * t * longint'(dim) >= (64'd1 << 34)) begin
                hi = mid;
            end else begin
                lo = mid + 1;
            end
        end
        return 17'(lo);
    endfunction

endpackage

// ----- src/tsms_front.sv -----
// Front end: accepts element transfers, collects one step's vectors and pushes them.
// Depends on tsms_pkg.
module tsms_front
    import tsms_pkg::*;
#(
    parameter int unsigned DIM = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_sequence_start,
    input  t_q88                  i_q_value,
    input  t_q88                  i_k_value,
    input  t_q88                  i_v_value,
    input  t_q88                  i_forget_value,
    input  t_q88                  i_write_gain,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_step_ctl             o_ctl,
    output logic [DIM-1:0][15:0]  o_qv,
    output logic [DIM-1:0][15:0]  o_kv,
    output logic [DIM-1:0][15:0]  o_vv,
    output logic [DIM-1:0][15:0]  o_fv
);

    localparam int unsigned IW = (DIM > 1) ? $clog2(DIM) : 1;
    localparam logic [IW-1:0] LastIx = IW'(DIM - 1);

    logic [IW-1:0] r_cnt;
    logic          r_clr;
    t_q88          r_qb [DIM];
    t_q88          r_kb [DIM];
    t_q88          r_vb [DIM];
    t_q88          r_fb [DIM];
    logic          w_accept;
    logic          w_last;

    // Hold off the last element while the queue slot is taken
    assign w_last     = (r_cnt == LastIx);
    assign o_in_stall = w_last && i_q_full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_push     = w_accept && w_last;

    // Element counter and sticky clear request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_clr <= 1'b0;
        end else if (w_accept) begin
            if (w_last) begin
                r_cnt <= '0;
                r_clr <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
                r_clr <= r_clr | i_sequence_start;
            end
        end
    end

    // Collect element values
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_qb[r_cnt] <= i_q_value;
            r_kb[r_cnt] <= i_k_value;
            r_vb[r_cnt] <= i_v_value;
            r_fb[r_cnt] <= i_forget_value;
        end
    end

    // Assemble the step, the last element straight from the ports
    always_comb begin
        for (int e = 0; e < DIM; e++) begin
            if (e == DIM - 1) begin
                o_qv[e] = i_q_value;
                o_kv[e] = i_k_value;
                o_vv[e] = i_v_value;
                o_fv[e] = i_forget_value;
            end else begin
                o_qv[e] = r_qb[e];
                o_kv[e] = r_kb[e];
                o_vv[e] = r_vb[e];
                o_fv[e] = r_fb[e];
            end
        end
        o_ctl.clear = r_clr | i_sequence_start;
        o_ctl.gain  = i_write_gain;
    end

endmodule

// ----- src/tsms_queue.sv -----
// One-entry step queue between the front end and the back end.
// Depends on tsms_pkg.
module tsms_queue
    import tsms_pkg::*;
#(
    parameter int unsigned DIM = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_pop,
    input  t_step_ctl             i_ctl,
    input  logic [DIM-1:0][15:0]  i_qv,
    input  logic [DIM-1:0][15:0]  i_kv,
    input  logic [DIM-1:0][15:0]  i_vv,
    input  logic [DIM-1:0][15:0]  i_fv,
    output logic                  o_full,
    output t_step_ctl             o_ctl,
    output logic [DIM-1:0][15:0]  o_qv,
    output logic [DIM-1:0][15:0]  o_kv,
    output logic [DIM-1:0][15:0]  o_vv,
    output logic [DIM-1:0][15:0]  o_fv
);

    logic r_full;

    assign o_full = r_full;

    // Occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_push) begin
            r_full <= 1'b1;
        end else if (i_pop) begin
            r_full <= 1'b0;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            o_ctl <= i_ctl;
            o_qv  <= i_qv;
            o_kv  <= i_kv;
            o_vv  <= i_vv;
            o_fv  <= i_fv;
        end
    end

endmodule

// ----- src/tsms_back.sv -----
// Back end: prediction, update and read-out passes over the memory and surprise arrays.
// Depends on tsms_pkg.
module tsms_back
    import tsms_pkg::*;
#(
    parameter int unsigned DIM = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_q88                  i_momentum,
    input  logic                  i_q_full,
    input  t_step_ctl             i_ctl,
    input  logic [DIM-1:0][15:0]  i_qv,
    input  logic [DIM-1:0][15:0]  i_kv,
    input  logic [DIM-1:0][15:0]  i_vv,
    input  logic [DIM-1:0][15:0]  i_fv,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_q88                  o_y_value,
    output logic                  o_last_result
);

    localparam int unsigned NE = DIM * DIM;
    localparam int unsigned IW = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int unsigned AW = (NE > 1) ? $clog2(NE) : 1;
    localparam logic [IW-1:0] LastIx = IW'(DIM - 1);
    localparam logic [16:0] Scale = inv_root(DIM);
    localparam logic signed [49:0] HalfD = 50'sh800000;

    t_back_state r_state, n_state;

    // Arrays and valid bits
    t_q88          r_mem [NE];
    t_q88          r_sur [NE];
    logic [NE-1:0] r_vld;
    t_q88          r_err [DIM];
    t_q88          r_y   [DIM];

    // Sequencing
    logic          r_issue_on;
    logic [IW-1:0] r_ci, r_cj, r_ecnt;
    logic          r_v1, r_v2, r_v3, r_v4;
    logic          w_issue, w_enter, w_done, w_out_xfer;
    logic [AW-1:0] w_addr;

    // Pipeline payload
    t_q88                r_mq, r_sq;
    logic                r_vq;
    logic [IW-1:0]       r_i1, r_j1, r_i2, r_i3, r_i4;
    logic [AW-1:0]       r_a1, r_a2, r_a3, r_a4;
    logic signed [31:0]  r_p1;
    logic signed [49:0]  r_prod2;
    t_q88                r_m2, r_s2, r_m3, r_m4, r_s4, r_d3;
    logic signed [31:0]  r_ms3;
    logic signed [16:0]  r_best;

    // Stage logic
    t_q88                w_m1, w_s1, w_addr_el, w_rd, w_err, w_delta, w_s, w_new;
    logic signed [16:0]  w_z, w_best;
    logic signed [49:0]  w_pr;
    logic signed [31:0]  w_gd;
    logic signed [32:0]  w_sacc;
    logic signed [17:0]  w_decay;
    logic signed [33:0]  w_dm;
    logic signed [34:0]  w_macc;

    assign w_done = !r_issue_on && !(r_v1 || r_v2 || r_v3 || r_v4);
    assign w_addr = AW'(int'(r_ci) * DIM + int'(r_cj));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: if (i_q_full) n_state = BK_PRED;
            BK_PRED: if (w_done) n_state = BK_UPD;
            BK_UPD:  if (w_done) n_state = BK_READ;
            BK_READ: if (w_done) n_state = BK_EMIT;
            BK_EMIT: if (w_out_xfer && r_ecnt == LastIx) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_out_valid   = (r_state == BK_EMIT);
        o_y_value     = r_y[r_ecnt];
        o_last_result = (r_ecnt == LastIx);
        w_out_xfer    = o_out_valid && !i_out_stall;
        o_pop         = w_out_xfer && (r_ecnt == LastIx);
        w_issue       = r_issue_on;
        w_enter       = (n_state != r_state) &&
                        (n_state == BK_PRED || n_state == BK_UPD || n_state == BK_READ);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_IDLE;
            r_issue_on <= 1'b0;
            r_ci       <= '0;
            r_cj       <= '0;
            r_ecnt     <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_v4       <= 1'b0;
            r_vld      <= '0;
        end else begin
            r_state <= n_state;
            r_v1    <= w_issue;
            r_v2    <= r_v1 && (r_state == BK_UPD);
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            // advance the address counters, row index fastest
            if (w_enter) begin
                r_issue_on <= 1'b1;
                r_ci       <= '0;
                r_cj       <= '0;
            end else if (w_issue) begin
                if (r_ci == LastIx) begin
                    r_ci <= '0;
                    if (r_cj == LastIx) begin
                        r_issue_on <= 1'b0;
                    end else begin
                        r_cj <= r_cj + 1'b1;
                    end
                end else begin
                    r_ci <= r_ci + 1'b1;
                end
            end
            // emit counter
            if (r_state != BK_EMIT) begin
                r_ecnt <= '0;
            end else if (w_out_xfer) begin
                r_ecnt <= r_ecnt + 1'b1;
            end
            // drop all entries on sequence start, mark written entries
            if (r_state == BK_IDLE && n_state == BK_PRED && i_ctl.clear) begin
                r_vld <= '0;
            end else if (r_v4) begin
                r_vld[r_a4] <= 1'b1;
            end
        end
    end

    // Memory ports
    always_ff @(posedge i_clk) begin
        if (r_v4) begin
            r_mem[r_a4] <= w_new;
            r_sur[r_a4] <= r_s4;
        end
        if (w_issue) begin
            r_mq <= r_mem[w_addr];
            r_sq <= r_sur[w_addr];
            r_vq <= r_vld[w_addr];
        end
    end

    // Max-plus read datapath
    always_comb begin
        w_m1      = r_vq ? r_mq : '0;
        w_s1      = r_vq ? r_sq : '0;
        w_addr_el = (r_state == BK_PRED) ? $signed(i_kv[r_i1]) : $signed(i_qv[r_i1]);
        w_z       = 17'(w_m1) + 17'(w_addr_el);
        w_best    = (r_i1 == '0 || w_z > r_best) ? w_z : r_best;
        w_rd      = sat16(64'(w_best));
        w_err     = sat16(64'($signed(i_vv[r_j1])) - 64'(w_rd));
    end

    // Update datapath
    always_comb begin
        w_pr    = r_prod2 + HalfD;
        w_delta = sat16(64'(w_pr >>> 24));
        w_gd    = i_ctl.gain * r_d3;
        w_sacc  = 33'(r_ms3) + 33'(w_gd) + 33'sd128;
        w_s     = sat16(64'(w_sacc >>> 8));
        w_decay = 18'sd256 - 18'($signed(i_fv[r_i4]));
        w_dm    = w_decay * r_m4;
        w_macc  = 35'(w_dm) + (35'(r_s4) <<< 8) + 35'sd128;
        w_new   = sat16(64'(w_macc >>> 8));
    end

    // Pipeline payload registers
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_i1 <= r_ci;
            r_j1 <= r_cj;
            r_a1 <= w_addr;
            r_p1 <= $signed(i_kv[r_ci]) * r_err[r_cj];
        end
        if (r_v1 && r_state != BK_UPD) begin
            r_best <= w_best;
            if (r_i1 == LastIx) begin
                if (r_state == BK_PRED) begin
                    r_err[r_j1] <= w_err;
                end else begin
                    r_y[r_j1] <= w_rd;
                end
            end
        end
        if (r_v1) begin
            r_prod2 <= r_p1 * $signed({1'b0, Scale});
            r_m2    <= w_m1;
            r_s2    <= w_s1;
            r_i2    <= r_i1;
            r_a2    <= r_a1;
        end
        if (r_v2) begin
            r_ms3 <= i_momentum * r_s2;
            r_d3  <= w_delta;
            r_m3  <= r_m2;
            r_i3  <= r_i2;
            r_a3  <= r_a2;
        end
        if (r_v3) begin
            r_s4 <= w_s;
            r_m4 <= r_m3;
            r_i4 <= r_i3;
            r_a4 <= r_a3;
        end
    end

endmodule

// ----- src/tropical_surprise_memory_scan_top.sv -----
// Top level of the max-plus surprise memory scan: configuration register and wiring.
// Depends on tsms_pkg, tsms_front, tsms_queue and tsms_back.
//
//  channel | handshake                  | payload
//  --------+----------------------------+----------------------------------------------
//  input   | i_in_valid / o_in_stall    | sequence_start, q, k, v, forget, write_gain
//  output  | o_out_valid / i_out_stall  | y_value, last_result
//  config  | i_cfg_wr_en                | i_cfg_wr_data (momentum)
//
// Elements are taken one per cycle; the last element of a step waits while the
// previous step is still in the back end. A step takes three passes over the DIM*DIM
// memory entries and DIM output transfers, and takes longer while the output stalls.
// Reset is synchronous and clears the arrays through their valid bits at once.
// Either side may stall at any time; a stalled result holds.
module tropical_surprise_memory_scan_top
    import tsms_pkg::*;
#(
    parameter int unsigned DIM = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_wr_en,
    input  t_q88 i_cfg_wr_data,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic i_sequence_start,
    input  t_q88 i_q_value,
    input  t_q88 i_k_value,
    input  t_q88 i_v_value,
    input  t_q88 i_forget_value,
    input  t_q88 i_write_gain,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_q88 o_y_value,
    output logic o_last_result
);

    t_q88                 r_momentum;
    logic                 w_push, w_pop, w_q_full;
    t_step_ctl            w_f_ctl, w_q_ctl;
    logic [DIM-1:0][15:0] w_f_qv, w_f_kv, w_f_vv, w_f_fv;
    logic [DIM-1:0][15:0] w_q_qv, w_q_kv, w_q_vv, w_q_fv;

    // Momentum register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_momentum <= '0;
        end else if (i_cfg_wr_en) begin
            r_momentum <= i_cfg_wr_data;
        end
    end

    tsms_front #(.DIM(DIM)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_sequence_start (i_sequence_start),
        .i_q_value        (i_q_value),
        .i_k_value        (i_k_value),
        .i_v_value        (i_v_value),
        .i_forget_value   (i_forget_value),
        .i_write_gain     (i_write_gain),
        .i_q_full         (w_q_full),
        .o_push           (w_push),
        .o_ctl            (w_f_ctl),
        .o_qv             (w_f_qv),
        .o_kv             (w_f_kv),
        .o_vv             (w_f_vv),
        .o_fv             (w_f_fv)
    );

    tsms_queue #(.DIM(DIM)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .i_ctl   (w_f_ctl),
        .i_qv    (w_f_qv),
        .i_kv    (w_f_kv),
        .i_vv    (w_f_vv),
        .i_fv    (w_f_fv),
        .o_full  (w_q_full),
        .o_ctl   (w_q_ctl),
        .o_qv    (w_q_qv),
        .o_kv    (w_q_kv),
        .o_vv    (w_q_vv),
        .o_fv    (w_q_fv)
    );

    tsms_back #(.DIM(DIM)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_momentum    (r_momentum),
        .i_q_full      (w_q_full),
        .i_ctl         (w_q_ctl),
        .i_qv          (w_q_qv),
        .i_kv          (w_q_kv),
        .i_vv          (w_q_vv),
        .i_fv          (w_q_fv),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_y_value     (o_y_value),
        .o_last_result (o_last_result)
    );

    // Results only come from a step held in the queue
    a_out_needs_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> w_q_full)
        else $error("result shown without a queued step");

    // The final result transfer frees the queue slot
    a_last_frees_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_result) |=> !w_q_full)
        else $error("queue slot not released after last result");

    // Input is held off only while the queue slot is taken
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> w_q_full)
        else $error("input stalled with a free queue slot");

endmodule
